// File: design/plcm_pkg.sv
// Shared types and constants for the piecewise-linear ARGB color map.
// Used by every module of the block; no dependencies.
package plcm_pkg;

  localparam int POS_W          = 9;
  localparam int COLOR_W        = 32;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = COLOR_W / CH_W;
  localparam int IDX_W          = 8;
  localparam int CFG_W          = POS_W + COLOR_W;
  localparam int CFG_IDX_W      = 3;
  localparam int SEG_W          = 3;
  localparam int POINT_REGS     = 6;
  localparam int NUM_W          = POS_W + CH_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = CH_W / BITS_PER_STAGE;
  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_PTR_W     = 1;
  localparam int FIFO_CNT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd6;
  localparam logic [SEG_W-1:0]     SEG_COUNT_RESET   = 3'd1;

  typedef struct packed {
    logic               covered;
    logic [POS_W-1:0]   d;
    logic [POS_W-1:0]   seg_len;
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
  } plcm_item_t;

endpackage

// File: design/plcm_front.sv
// Front end: accepts level indexes, finds the covering segment and registers the request.
// Depends on plcm_pkg.
module plcm_front #(
  parameter int NUM_PTS       = 6,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [plcm_pkg::IDX_W-1:0]            in_level_index,
  input  logic [plcm_pkg::CFG_W-1:0]            points [NUM_PTS],
  input  logic [plcm_pkg::SEG_W-1:0]            segment_count,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output plcm_pkg::plcm_item_t                  push_data
);
  import plcm_pkg::*;

  logic       vld_r;
  plcm_item_t item_r;
  plcm_item_t item_nxt;
  logic [SEG_W-1:0] segs_lim;

  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_data  = item_r;

  assign segs_lim = (segment_count > SEG_W'(NUM_PTS - 1)) ? SEG_W'(NUM_PTS - 1) : segment_count;

  always_comb begin
    logic [POS_W-1:0] v1;
    logic [POS_W-1:0] v2;
    logic [POS_W-1:0] idx_ext;
    logic             in_table;
    idx_ext          = {1'b0, in_level_index};
    in_table         = idx_ext < POS_W'(TABLE_ENTRIES);
    item_nxt         = '0;
    item_nxt.seg_len = POS_W'(1);
    // lowest segment wins: scan from the top down
    for (int k = NUM_PTS - 2; k >= 0; k--) begin
      v1 = points[k][CFG_W-1:COLOR_W];
      v2 = points[k+1][CFG_W-1:COLOR_W];
      if (in_table && (SEG_W'(k) < segs_lim) && (v1 <= idx_ext) && (idx_ext < v2)) begin
        item_nxt.covered = 1'b1;
        item_nxt.d       = idx_ext - v1;
        item_nxt.seg_len = v2 - v1;
        item_nxt.c1      = points[k][COLOR_W-1:0];
        item_nxt.c2      = points[k+1][COLOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: design/plcm_fifo.sv
// Two-entry request queue between the front end and the interpolation back end.
// Depends on plcm_pkg.
module plcm_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  plcm_pkg::plcm_item_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output plcm_pkg::plcm_item_t pop_data
);
  import plcm_pkg::*;

  plcm_item_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  cnt_r;
  logic [FIFO_CNT_W-1:0]  cnt_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = cnt_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/plcm_back.sv
// Back end: weighted channel sums, then a pipelined restoring divide, two quotient bits a stage.
// Depends on plcm_pkg.
module plcm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  plcm_pkg::plcm_item_t          pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [plcm_pkg::COLOR_W-1:0]  out_argb_color,
  output logic                          out_covered
);
  import plcm_pkg::*;

  localparam int LAST = DIV_STAGES;

  logic [LAST:0]       vld_r;
  logic [LAST:0]       stg_rdy;
  logic [NUM_W-1:0]    rem_r   [LAST+1][NUM_CH];
  logic [NUM_W-1:0]    rem_nxt [LAST+1][NUM_CH];
  logic [CH_W-1:0]     q_r     [LAST+1][NUM_CH];
  logic [CH_W-1:0]     q_nxt   [LAST+1][NUM_CH];
  logic [POS_W-1:0]    div_r   [LAST+1];
  logic [POS_W-1:0]    div_nxt [LAST+1];
  logic [LAST:0]       cov_r;
  logic [LAST:0]       cov_nxt;

  always_comb begin
    stg_rdy[LAST] = !vld_r[LAST] || out_ready;
    for (int s = LAST - 1; s >= 0; s--) begin
      stg_rdy[s] = !vld_r[s] || stg_rdy[s+1];
    end
  end

  assign pop_ready = stg_rdy[0];

  always_comb begin
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] trial;
    logic [CH_W-1:0]  q;
    int               bpos;
    div_nxt[0] = pop_data.seg_len;
    cov_nxt[0] = pop_data.covered;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      rem_nxt[0][ch] =
        NUM_W'(NUM_W'(pop_data.d) * NUM_W'(pop_data.c2[ch*CH_W +: CH_W])) +
        NUM_W'(NUM_W'(pop_data.seg_len - pop_data.d) * NUM_W'(pop_data.c1[ch*CH_W +: CH_W]));
      q_nxt[0][ch] = '0;
    end
    for (int s = 1; s <= LAST; s++) begin
      div_nxt[s] = div_r[s-1];
      cov_nxt[s] = cov_r[s-1];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        r = rem_r[s-1][ch];
        q = q_r[s-1][ch];
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
          bpos  = CH_W - 1 - (s - 1) * BITS_PER_STAGE - b;
          trial = NUM_W'(div_r[s-1]) << bpos;
          if (r >= trial) begin
            r       = r - trial;
            q[bpos] = 1'b1;
          end
        end
        rem_nxt[s][ch] = r;
        q_nxt[s][ch]   = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_rdy[0]) begin
        vld_r[0] <= pop_valid;
      end
      for (int s = 1; s <= LAST; s++) begin
        if (stg_rdy[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= LAST; s++) begin
      if (stg_rdy[s]) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        div_r[s] <= div_nxt[s];
        cov_r[s] <= cov_nxt[s];
      end
    end
  end

  assign out_valid   = vld_r[LAST];
  assign out_covered = cov_r[LAST];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      out_argb_color[ch*CH_W +: CH_W] = q_r[LAST][ch];
    end
  end

endmodule

// File: design/piecewise_linear_argb_colormap_core.sv
// Piecewise-linear ARGB color map: top level with the control-point registers.
// Depends on plcm_pkg, plcm_front, plcm_fifo and plcm_back.
//
// Usage:
//   Input channel in_valid/in_ready carries an 8-bit level index; the result
//   channel out_valid/out_ready returns one 32-bit ARGB color and a covered
//   flag per index, in order. An index outside every segment in use returns
//   covered = 0 and color 0.
//   Control points and the segment count are written through cfg_we,
//   cfg_index and cfg_data (index 0..5 points, 6 segment count) while idle.
//   Throughput: one index per cycle, sustained while out_ready is held high.
//   Pipeline: one front register, a slot in the request queue, one
//   multiply stage and four divide stages of two quotient bits each, the
//   last being the output register.
//   Reset (rst_n low, synchronous) empties the pipeline, clears all points
//   to zero and sets the segment count to one.
//   When the receiver holds out_ready low, the result stays on the port and
//   the back end fills; the two-entry request queue and the front register
//   keep taking indexes until they are full, then in_ready drops.
module piecewise_linear_argb_colormap_core #(
  parameter int MAX_POINTS    = 6,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plcm_pkg::IDX_W-1:0]        in_level_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [plcm_pkg::COLOR_W-1:0]      out_argb_color,
  output logic                              out_covered,
  input  logic                              cfg_we,
  input  logic [plcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plcm_pkg::CFG_W-1:0]        cfg_data
);
  import plcm_pkg::*;

  localparam int NUM_PTS = (MAX_POINTS < POINT_REGS) ? MAX_POINTS : POINT_REGS;

  logic [CFG_W-1:0] point_r [NUM_PTS];
  logic [SEG_W-1:0] seg_cnt_r;

  logic       push_valid;
  logic       push_ready;
  plcm_item_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  plcm_item_t pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= SEG_COUNT_RESET;
      for (int i = 0; i < NUM_PTS; i++) begin
        point_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SEGMENT_COUNT) begin
        seg_cnt_r <= cfg_data[SEG_W-1:0];
      end
      for (int i = 0; i < NUM_PTS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          point_r[i] <= cfg_data;
        end
      end
    end
  end

  plcm_front #(
    .NUM_PTS       (NUM_PTS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_level_index (in_level_index),
    .points         (point_r),
    .segment_count  (seg_cnt_r),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  plcm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  plcm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_argb_color (out_argb_color),
    .out_covered    (out_covered)
  );

  a_uncovered_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> out_argb_color == '0)
    else $error("uncovered result carries a nonzero color");

  a_covered_needs_segments: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_covered |-> seg_cnt_r != '0)
    else $error("covered result with no segments in use");

  a_reset_drains: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !pop_valid && !push_valid)
    else $error("pipeline not empty after reset");

  a_queue_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> push_valid && !push_ready)
    else $error("input stalled while the front register could drain");

endmodule
